FILE: hdl/swec_pkg.sv
package swec_pkg;

  localparam int RING_DEPTH = 256;
  localparam int IDX_W      = $clog2(RING_DEPTH);

  localparam int NOW_W      = 62;
  localparam int EXP_W      = 63;
  localparam int WIN_W      = 12;
  localparam int WIN_NS_W   = 42;
  localparam int COUNT_W    = 8;

  localparam logic [WIN_NS_W-1:0] NS_PER_SEC     = WIN_NS_W'(64'd1000000000);
  localparam logic [WIN_W-1:0]    WIN_SEC_RESET  = WIN_W'(3);
  localparam logic [WIN_NS_W-1:0] WIN_NS_RESET   = WIN_NS_W'(64'd3000000000);

  localparam logic OP_EVENT = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [EXP_W-1:0] expiry_t;

  function automatic idx_t ring_next(input idx_t i);
    return (i == IDX_W'(RING_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic idx_t ring_count(input idx_t head, input idx_t tail);
    idx_t diff;
    diff = (head >= tail) ? head - tail : head + IDX_W'(RING_DEPTH) - tail;
    return diff;
  endfunction

  function automatic logic [COUNT_W-1:0] sat_count(input idx_t c);
    logic [IDX_W+COUNT_W-1:0] wide;
    wide = (IDX_W + COUNT_W)'(c);
    return (wide > (IDX_W + COUNT_W)'(255)) ? {COUNT_W{1'b1}} : wide[COUNT_W-1:0];
  endfunction

endpackage

FILE: hdl/sliding_window_event_counter.sv
// Channel  Direction  tdata (low bit up)                     tuser
// in_      slave      now_ns[61:0], zero pad to 64 bits       opcode
// out_     master     live_count[7:0], stored, zero pad to 16 -
// cfg_     write      window_seconds[11:0]                   -
// An accepted item goes to S_POP; while the ring holds entries, each read leads to S_CMP,
// where an expired entry is popped and the loop returns to S_POP. The item ends in S_FIN
// when the ring is empty or an entry has not expired; ring read data is registered.
// Reset clears the indices and the state machine; the ring memory needs no clearing pass.
// A result waits in the output register while the next word is accepted; only the final
// step (S_FIN) waits for that register to drain.
module sliding_window_event_counter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // now_ns[61:0], zero pad
  input  logic        in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // live_count[7:0], stored, zero pad
  input  logic        cfg_wen,
  input  logic [11:0] cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_POP  = 4'b0010,
    S_CMP  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t                                state_r, state_nxt;
  swec_pkg::idx_t                        head_r, head_nxt;
  swec_pkg::idx_t                        tail_r, tail_nxt;
  logic                                  op_r;
  logic [swec_pkg::NOW_W-1:0]            now_r;
  logic [swec_pkg::WIN_NS_W-1:0]         win_ns_r;
  logic                                  out_valid_r, out_valid_nxt;
  logic [swec_pkg::COUNT_W-1:0]          out_count_r;
  logic                                  out_stored_r;

  swec_pkg::idx_t                        count;
  logic                                  ram_we;
  logic                                  ram_re;
  swec_pkg::expiry_t                     ram_rdata;
  swec_pkg::expiry_t                     new_expiry;
  logic                                  fin_go;
  logic                                  do_store;

  swec_ring_ram u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head_r),
    .wdata (new_expiry),
    .re    (ram_re),
    .raddr (tail_r),
    .rdata (ram_rdata)
  );

  assign count      = swec_pkg::ring_count(head_r, tail_r);
  assign new_expiry = swec_pkg::EXP_W'(now_r) + swec_pkg::EXP_W'(win_ns_r);
  assign fin_go     = (state_r == S_FIN) && (!out_valid_r || out_tready);
  assign do_store   = (op_r == swec_pkg::OP_EVENT) &&
                      (count != swec_pkg::IDX_W'(swec_pkg::RING_DEPTH - 1));
  assign ram_we     = fin_go && do_store;
  assign ram_re     = (state_r == S_POP) && (count != '0);
  assign in_tready  = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        state_nxt = (count != '0) ? S_CMP : S_FIN;
      end
      S_CMP: begin
        if (swec_pkg::EXP_W'(now_r) > ram_rdata) begin
          tail_nxt  = swec_pkg::ring_next(tail_r);
          state_nxt = S_POP;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          state_nxt = S_IDLE;
          if (do_store) begin
            head_nxt = swec_pkg::ring_next(head_r);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (fin_go) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
      win_ns_r    <= swec_pkg::WIN_NS_RESET;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wen) begin
        win_ns_r <= swec_pkg::WIN_NS_W'(cfg_wdata) * swec_pkg::NS_PER_SEC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r  <= in_tuser;
      now_r <= in_tdata[swec_pkg::NOW_W-1:0];
    end
    if (fin_go) begin
      out_stored_r <= do_store;
      out_count_r  <= swec_pkg::sat_count(do_store ? count + 1'b1 : count);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_stored_r, out_count_r};

`ifndef NO_ASSERTIONS
  a_store_only_at_fin: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_FIN) && (op_r == swec_pkg::OP_EVENT))
    else $error("ring written outside the store step");

  a_tail_moves_in_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (tail_r != $past(tail_r)) |-> ($past(state_r) == S_CMP))
    else $error("tail index moved outside the compare step");

  a_stored_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8] |-> (out_tdata[7:0] != 8'd0))
    else $error("stored word reports an empty ring");

  a_accept_starts_pop: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> (state_r == S_POP))
    else $error("accepted word did not start the pop loop");
`endif

endmodule

FILE: hdl/swec_ring_ram.sv
module swec_ring_ram (
  input  logic              clk,
  input  logic              we,
  input  swec_pkg::idx_t    waddr,
  input  swec_pkg::expiry_t wdata,
  input  logic              re,
  input  swec_pkg::idx_t    raddr,
  output swec_pkg::expiry_t rdata
);

  swec_pkg::expiry_t mem [swec_pkg::RING_DEPTH];
  swec_pkg::expiry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_WORDS   = 230;
  localparam logic [swec_pkg::NOW_W-1:0] NOW_MAX = {swec_pkg::NOW_W{1'b1}};

  typedef struct packed {
    logic [swec_pkg::COUNT_W-1:0] live_count;
    logic                         stored;
  } tally_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // now_ns[61:0], zero pad
  logic        in_tuser = 1'b0; // opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // live_count[7:0], stored, zero pad
  logic        cfg_wen = 1'b0;
  logic [11:0] cfg_wdata = '0;

  logic [swec_pkg::EXP_W-1:0] expiry_mem [swec_pkg::RING_DEPTH];
  int unsigned                head_ptr;
  int unsigned                tail_ptr;
  logic [swec_pkg::WIN_W-1:0] window_sec;
  logic [swec_pkg::NOW_W-1:0] now_cursor;

  tally_t      expected_tallies[$];
  int unsigned mismatches = 0;
  bit          idle_on = 1'b1;
  int unsigned ready_hold = 0;

  sliding_window_event_counter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] rand64(input logic [63:0] max);
    logic [63:0] v;
    v = {$urandom, $urandom};
    if (max == '1) return v;
    return v % (max + 64'd1);
  endfunction

  function automatic int unsigned next_slot(input int unsigned i);
    return (i + 1 >= swec_pkg::RING_DEPTH) ? 0 : i + 1;
  endfunction

  function automatic int unsigned ring_fill();
    return (head_ptr + swec_pkg::RING_DEPTH - tail_ptr) % swec_pkg::RING_DEPTH;
  endfunction

  function automatic tally_t count_window_events(input logic op,
                                                 input logic [swec_pkg::NOW_W-1:0] now);
    tally_t      t;
    int unsigned held;
    while (ring_fill() != 0 && swec_pkg::EXP_W'(now) > expiry_mem[tail_ptr])
      tail_ptr = next_slot(tail_ptr);
    t.stored = 1'b0;
    if (op == swec_pkg::OP_EVENT && ring_fill() < swec_pkg::RING_DEPTH - 1) begin
      expiry_mem[head_ptr] = swec_pkg::EXP_W'(now) +
                             swec_pkg::EXP_W'(window_sec) *
                             swec_pkg::EXP_W'(swec_pkg::NS_PER_SEC);
      head_ptr = next_slot(head_ptr);
      t.stored = 1'b1;
    end
    held = ring_fill();
    t.live_count = (held > 255) ? swec_pkg::COUNT_W'(255) : swec_pkg::COUNT_W'(held);
    return t;
  endfunction

  always @(posedge clk) begin
    if (ready_hold != 0) begin
      out_tready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else begin
      out_tready <= 1'b1;
      if (idle_on && $urandom_range(0, 3) == 0) ready_hold <= gap_len();
    end
  end

  always @(posedge clk) begin : check_result
    tally_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_tallies.size() == 0) begin
        $error("result word with no expectation: live_count %0d, stored %0d",
               out_tdata[7:0], out_tdata[8]);
        mismatches++;
      end else begin
        want = expected_tallies.pop_front();
        if (out_tdata[7:0] !== want.live_count) begin
          $error("live_count: expected %0d, actual %0d", want.live_count, out_tdata[7:0]);
          mismatches++;
        end
        if (out_tdata[8] !== want.stored) begin
          $error("stored: expected %0d, actual %0d", want.stored, out_tdata[8]);
          mismatches++;
        end
      end
    end
  end

  task automatic send_word(input logic op, input logic [swec_pkg::NOW_W-1:0] now);
    int unsigned gap;
    gap = (idle_on && $urandom_range(0, 9) < 4) ? gap_len() : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= 64'(now);
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    now_cursor = now;
    expected_tallies.push_back(count_window_events(op, now));
  endtask

  task automatic wait_for_tallies();
    in_tvalid <= 1'b0;
    while (expected_tallies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [swec_pkg::WIN_W-1:0] value);
    wait_for_tallies();
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    window_sec = value;
  endtask

  task automatic test_directed();
    send_word(swec_pkg::OP_EVENT, 62'd0);
    send_word(swec_pkg::OP_QUERY, 62'd0);
    send_word(swec_pkg::OP_QUERY, 62'd3000000000);
    send_word(swec_pkg::OP_QUERY, 62'd3000000001);
    send_word(swec_pkg::OP_EVENT, 62'd100);
    send_word(swec_pkg::OP_EVENT, 62'd100);
    send_word(swec_pkg::OP_QUERY, 62'h1555_5555_5555_5555);
    send_word(swec_pkg::OP_EVENT, 62'h1555_5555_5555_5555);
    send_word(swec_pkg::OP_QUERY, 62'h2AAA_AAAA_AAAA_AAAA);
    send_word(swec_pkg::OP_QUERY, NOW_MAX);
    write_window(12'd0);
    send_word(swec_pkg::OP_EVENT, 62'd1000);
    send_word(swec_pkg::OP_QUERY, 62'd1000);
    send_word(swec_pkg::OP_QUERY, 62'd1001);
    send_word(swec_pkg::OP_EVENT, 62'd2000);
    send_word(swec_pkg::OP_EVENT, 62'd2000);
    send_word(swec_pkg::OP_QUERY, 62'd2001);
    write_window(12'd4095);
    send_word(swec_pkg::OP_EVENT, 62'd5000);
    send_word(swec_pkg::OP_QUERY, 62'd4095000005000);
    send_word(swec_pkg::OP_QUERY, 62'd4095000005001);
  endtask

  task automatic test_ring_full();
    logic [swec_pkg::NOW_W-1:0] t;
    write_window(12'd4095);
    idle_on = 1'b0;
    t = swec_pkg::NOW_W'(rand64(64'd1 << 40));
    for (int i = 0; i < 270; i++) begin
      t = t + swec_pkg::NOW_W'($urandom_range(0, 1000));
      send_word(swec_pkg::OP_EVENT, t);
    end
    idle_on = 1'b1;
    for (int i = 0; i < 3; i++) send_word(swec_pkg::OP_QUERY, t);
    for (int i = 0; i < 3; i++) send_word(swec_pkg::OP_EVENT, t);
    send_word(swec_pkg::OP_QUERY, t + swec_pkg::NOW_W'(64'd4096000000000));
    send_word(swec_pkg::OP_EVENT, t + swec_pkg::NOW_W'(64'd4096000000000));
  endtask

  task automatic run_random_phase(input logic [swec_pkg::WIN_W-1:0] window,
                                  input bit pause_midway);
    logic [63:0]      scale;
    logic [63:0]      t;
    logic [63:0]      back;
    int unsigned      r;
    logic             op;
    send_word(swec_pkg::OP_QUERY, now_cursor + swec_pkg::NOW_W'(64'd4096000000001));
    write_window(window);
    idle_on = $urandom_range(0, 3) != 0;
    scale = (window == 0) ? 64'd1000 : 64'(window) * 64'd1000000000;
    t = rand64((64'd1 << 61) - 1);
    for (int i = 0; i < PHASE_WORDS; i++) begin
      if (pause_midway && i == PHASE_WORDS / 2) wait_for_tallies();
      r = $urandom_range(0, 99);
      if (r < 20) t = t + rand64(64'd3);
      else if (r < 65) t = t + rand64(scale / 64);
      else if (r < 85) t = t + rand64(scale / 4);
      else if (r < 90) t = t + 2 * scale + rand64(scale);
      else if (r < 95 && ring_fill() != 0)
        t = 64'(expiry_mem[tail_ptr]) + 64'($urandom_range(0, 1));
      else if (r < 97) begin
        back = (t < scale / 8) ? t : scale / 8;
        t = t - rand64(back);
      end else t = t + rand64(scale / 16);
      t = t & 64'(NOW_MAX);
      op = ($urandom_range(0, 3) == 0) ? swec_pkg::OP_QUERY : swec_pkg::OP_EVENT;
      send_word(op, swec_pkg::NOW_W'(t));
    end
  endtask

  task automatic test_random();
    run_random_phase(12'd0, 1'b0);
    run_random_phase(12'd3600, 1'b1);
    run_random_phase(12'd4095, 1'b0);
    run_random_phase(12'd1, 1'b0);
    run_random_phase(swec_pkg::WIN_W'($urandom_range(2, 3599)), 1'b0);
  endtask

  task automatic test_time_extremes();
    write_window(12'd4095);
    send_word(swec_pkg::OP_EVENT, NOW_MAX);
    send_word(swec_pkg::OP_QUERY, NOW_MAX);
    send_word(swec_pkg::OP_EVENT, 62'd0);
    send_word(swec_pkg::OP_QUERY, 62'd1);
    send_word(swec_pkg::OP_QUERY, NOW_MAX);
  endtask

  initial begin
    head_ptr   = 0;
    tail_ptr   = 0;
    window_sec = swec_pkg::WIN_SEC_RESET;
    now_cursor = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_ring_full();
    test_random();
    test_time_extremes();
    wait_for_tallies();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
